// File: rtl/sida_pkg.sv
// Shared types and constants for the signed integer to decimal ASCII converter.
`default_nettype none

package sida_pkg;

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;
  localparam int unsigned BCD_BITS   = 4;

  // controller -> datapath commands
  typedef struct packed {
    logic load;        // take a new value, clear the BCD accumulator
    logic step;        // one shift-and-add-3 step
    logic find;        // locate the most significant nonzero digit
    logic emit_sign;   // put '-' into the output register
    logic emit_digit;  // put the current digit into the output register
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic neg;         // value was negative
    logic step_last;   // this is the final conversion step
    logic idx_zero;    // current digit is the least significant one
    logic slot_free;   // output register can take a character this cycle
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/sida_datapath.sv
// Datapath: magnitude, double-dabble BCD accumulator, digit pointer and output register.
`default_nettype none

module sida_datapath #(
  parameter int VALUE_BITS = 32
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire  [VALUE_BITS-1:0]   value,
  input  sida_pkg::cmd_t          cmd,
  output sida_pkg::sts_t          sts,
  output logic                    out_valid,
  input  wire                     out_ready,
  output logic [7:0]              out_char,
  output logic                    out_last
);

  // digit count of 2^(VALUE_BITS-1)
  localparam int NDIG  = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
  localparam int IDXW  = $clog2(NDIG);
  localparam int CNTW  = $clog2(VALUE_BITS);
  localparam int BCDW  = NDIG * sida_pkg::BCD_BITS;

  logic [VALUE_BITS-1:0] mag;
  logic [BCDW-1:0]       bcd;
  logic [BCDW-1:0]       bcd_adj;
  logic                  neg;
  logic [CNTW-1:0]       cnt;
  logic [IDXW-1:0]       idx;
  logic [IDXW-1:0]       idx_next;
  logic [3:0]            digit;
  logic                  slot_free;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4];
      end
    end
  end

  // highest nonzero digit, zero if all digits are zero
  always_comb begin
    idx_next = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (bcd[i*4 +: 4] != 4'd0) begin
        idx_next = IDXW'(i);
      end
    end
  end

  assign digit     = bcd[{idx, 2'b00} +: 4];
  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg <= value[VALUE_BITS-1];
      mag <= value[VALUE_BITS-1] ? (~value + 1'b1) : value;
      bcd <= '0;
      cnt <= '0;
    end else if (cmd.step) begin
      bcd <= {bcd_adj[BCDW-2:0], mag[VALUE_BITS-1]};
      mag <= {mag[VALUE_BITS-2:0], 1'b0};
      cnt <= cnt + 1'b1;
    end
    if (cmd.find) begin
      idx <= idx_next;
    end else if (cmd.emit_digit && idx != '0) begin
      idx <= idx - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      out_char <= sida_pkg::ASCII_MINUS;
      out_last <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_char <= sida_pkg::ASCII_ZERO + {4'd0, digit};
      out_last <= (idx == '0);
    end
  end

  assign sts.neg       = neg;
  assign sts.step_last = (cnt == CNTW'(VALUE_BITS - 1));
  assign sts.idx_zero  = (idx == '0);
  assign sts.slot_free = slot_free;

endmodule

`default_nettype wire

// File: rtl/sida_ctrl.sv
// Controller state machine: conversion steps, digit search and character emission.
`default_nettype none

module sida_ctrl (
  input  wire             clk,
  input  wire             rst,
  input  wire             in_valid,
  output logic            in_ready,
  input  sida_pkg::sts_t  sts,
  output sida_pkg::cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CONV = 5'b00010,
    S_FIND = 5'b00100,
    S_SIGN = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CONV;
        end
      end
      S_CONV: begin
        cmd.step = 1'b1;
        if (sts.step_last) begin
          state_next = S_FIND;
        end
      end
      S_FIND: begin
        cmd.find   = 1'b1;
        state_next = sts.neg ? S_SIGN : S_EMIT;
      end
      S_SIGN: begin
        if (sts.slot_free) begin
          cmd.emit_sign = 1'b1;
          state_next    = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.slot_free) begin
          cmd.emit_digit = 1'b1;
          if (sts.idx_zero) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/signed_int_to_decimal_ascii.sv
// Top level: signed integer in, decimal ASCII characters out.
// Steps: take the item, VALUE_BITS shift-and-add-3 steps, a digit search, then one character per
// cycle while the output register is free (sign plus digits, up to 11 at 32 bits).
// A new item is taken only once the last character of the previous one is in the output register;
// the bit-serial BCD conversion and the single output register set this pace.
// Reset (rst, synchronous) returns the controller to idle and empties the output register.
`default_nettype none

module signed_int_to_decimal_ascii #(
  parameter int VALUE_BITS = 32
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 s_tvalid,
  output logic                                s_tready,
  input  wire  [((VALUE_BITS + 7) / 8)*8-1:0] s_tdata,   // value
  output logic                                m_tvalid,
  input  wire                                 m_tready,
  output logic [7:0]                          m_tdata,   // char_code
  output logic                                m_tlast    // last_char
);

  sida_pkg::cmd_t cmd;
  sida_pkg::sts_t sts;

  sida_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sida_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .value     (s_tdata[VALUE_BITS-1:0]),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_char  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

`default_nettype wire

// File: bench/decimal_text_checker.sv
// Checker for the decimal ASCII converter: predicts each run of characters and compares it.
`timescale 1ns / 1ps

module decimal_text_checker #(
  parameter int VALUE_BITS = 32,
  parameter int DATA_W     = ((VALUE_BITS + 7) / 8) * 8
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              s_tvalid,
  input  wire              s_tready,
  input  wire [DATA_W-1:0] s_tdata,
  input  wire              m_tvalid,
  input  wire              m_tready,
  input  wire [7:0]        m_tdata,
  input  wire              m_tlast,
  output int               errors,
  output int               pending
);

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  text_char_t chars_due[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  // Decimal text of one value: sign first, digits most significant first.
  task automatic spell_decimal(input logic [VALUE_BITS-1:0] v);
    logic [VALUE_BITS-1:0] mag;
    logic [63:0]           rest;
    logic [3:0]            digs[24];
    int                    n;
    text_char_t            c;
    n = 0;
    // two's complement negate stays exact for the most negative value when unsigned
    mag = v[VALUE_BITS-1] ? (~v + 1'b1) : v;
    rest = 64'(mag);
    if (rest == 64'd0) begin
      c.code = sida_pkg::ASCII_ZERO;
      c.last = 1'b1;
      chars_due.push_back(c);
    end else begin
      while (rest != 64'd0) begin
        digs[n] = 4'(rest % 64'd10);
        rest = rest / 64'd10;
        n++;
      end
      if (v[VALUE_BITS-1]) begin
        c.code = sida_pkg::ASCII_MINUS;
        c.last = 1'b0;
        chars_due.push_back(c);
      end
      for (int i = n - 1; i >= 0; i--) begin
        c.code = sida_pkg::ASCII_ZERO + 8'(digs[i]);
        c.last = (i == 0);
        chars_due.push_back(c);
      end
    end
  endtask

  always @(posedge clk) begin
    text_char_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (chars_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected char: code %0d last %0b", m_tdata, m_tlast);
      end else begin
        want = chars_due.pop_front();
        if (m_tdata !== want.code || m_tlast !== want.last) begin
          errors++;
          if (errors <= 10)
            $display("char mismatch: expected code %0d last %0b, got code %0d last %0b",
                     want.code, want.last, m_tdata, m_tlast);
        end
      end
    end
    if (!rst && s_tvalid && s_tready)
      spell_decimal(s_tdata[VALUE_BITS-1:0]);
    pending = chars_due.size();
  end

endmodule

// File: bench/signed_int_to_decimal_ascii_tb.sv
// Testbench top: drives values into the converter and reports the verdict.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_tb;

  localparam int VALUE_BITS  = 32;
  localparam int DATA_W      = ((VALUE_BITS + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_ITEMS = 200;

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata;
  logic              m_tvalid;
  logic              m_tready;
  logic [7:0]        m_tdata;
  logic              m_tlast;

  int   errors;
  int   pending;
  int   cycles;
  logic calm;        // no gaps and no stalls while set
  logic out_taken;
  int   hold;

  signed_int_to_decimal_ascii #(
    .VALUE_BITS(VALUE_BITS)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  decimal_text_checker #(
    .VALUE_BITS(VALUE_BITS)
  ) i_checker (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .errors  (errors),
    .pending (pending)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[signed_int_to_decimal_ascii] ERROR");
      $finish;
    end
  end

  // Output side: a stall drawn after every accepted char, counted down while a char waits.
  initial begin
    out_taken = 1'b0;
    hold = 0;
  end
  always @(posedge clk) out_taken <= m_tvalid && m_tready;
  always @(negedge clk) begin
    if (out_taken)
      hold = calm ? 0 : $urandom_range(0, 14);
    if (hold > 0) begin
      m_tready <= 1'b0;
      if (m_tvalid)
        hold--;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_value(input logic [VALUE_BITS-1:0] v);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= DATA_W'(v);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [VALUE_BITS-1:0] pow_ten(input int k);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < k; i++)
      p = p * 64'd10;
    return VALUE_BITS'(p);
  endfunction

  initial begin
    logic [VALUE_BITS-1:0] v;
    logic [VALUE_BITS-1:0] directed[$];
    int kind;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    m_tready = 1'b0;
    rst      = 1'b1;
    calm     = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    directed = '{32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99,
                 32'd100, 32'd12345, -32'sd12345, 32'd999999999, 32'd1000000000,
                 -32'sd1000000000, 32'h7fffffff, 32'h80000001, 32'h80000000,
                 32'h7ffffffe, 32'h55555555, 32'haaaaaaaa, 32'd1999999999,
                 -32'sd1999999999};
    foreach (directed[i]) begin
      if (i == 12)
        calm = 1'b1;   // back-to-back stretch
      send_value(directed[i]);
    end
    calm = 1'b0;

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 19) == 0)
        calm = ~calm;
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2, 3: v = $urandom;
        4, 5: v = VALUE_BITS'($urandom_range(0, 400)) - VALUE_BITS'(200);
        6, 7: begin
          // digit count boundaries: 10^k - 1, 10^k, 10^k + 1
          v = pow_ten($urandom_range(0, 9)) + VALUE_BITS'($urandom_range(0, 2)) - 1'b1;
          if ($urandom_range(0, 1) == 1)
            v = ~v + 1'b1;
        end
        8: begin
          if ($urandom_range(0, 1) == 1)
            v = 32'h80000000 + VALUE_BITS'($urandom_range(0, 3));
          else
            v = 32'h7fffffff - VALUE_BITS'($urandom_range(0, 3));
        end
        default: begin
          v = $urandom >> $urandom_range(0, 31);
          if ($urandom_range(0, 1) == 1)
            v = ~v + 1'b1;
        end
      endcase
      send_value(v);
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("[signed_int_to_decimal_ascii] OK");
    end else begin
      $display("[signed_int_to_decimal_ascii] ERROR");
    end
    $finish;
  end

endmodule
